[rtl/core/pidl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 3;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // wide enough for count + 1 and for the position field
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_BACK  = 3'd3,
    CMD_DEL_FRONT = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_READ_ALL  = 3'd6
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_BADPOS  = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // broadcast to every cell
  typedef struct packed {
    cell_op_e         op;
    logic [IDX_W-1:0] idx;   // edit slot
    logic [IDX_W-1:0] last;  // slot of the final held entry
  } cell_ctrl_t;

endpackage

[rtl/core/positional_insert_delete_list.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list
// Ordered list of signed words with insert/delete at front, back or position.
// ----------------------------------------------------------------------------
// Edits (insert, delete) and error requests can follow back to back: every
// cell of the chain shifts in the same cycle. A read-all request first enters
// the read state and then streams one entry per cycle while the output is
// not stalled, rotating the chain through its head cell; an empty read gives
// a single result. Results sit in an output register, and a new request is
// taken only in a cycle where that register is empty or is being drained by
// m_axis_tready; a result left waiting stalls the input. Entries are not
// cleared at reset; only the count, state, read index and output valid are.
module positional_insert_delete_list import pidl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [4:0] position, [36:5] value, [39:37] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] data
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);

  state_e                   state_d, state_q;
  logic [CNT_W-1:0]         count_d, count_q;
  logic [IDX_W-1:0]         rd_cnt_d, rd_cnt_q;
  logic                     out_valid_d, out_valid_q;
  status_e                  out_status_d, out_status_q;
  logic signed [DATA_W-1:0] out_data_d, out_data_q;
  logic                     out_last_d, out_last_q;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] head;

  logic [POS_W-1:0]         pos;
  logic signed [DATA_W-1:0] value;
  logic                     out_free, in_fire;
  logic                     full, empty, ins_pos_ok, del_pos_ok, rd_last;
  logic [CMP_W-1:0]         pos_ext, cnt_ext;
  logic [IDX_W-1:0]         pos_idx, last_idx;

  assign pos   = s_axis_tdata[POS_W-1:0];
  assign value = s_axis_tdata[POS_W +: DATA_W];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign full       = (count_q == CNT_W'(DEPTH));
  assign empty      = (count_q == '0);
  assign pos_ext    = CMP_W'(pos);
  assign cnt_ext    = CMP_W'(count_q);
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign del_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_idx    = IDX_W'(pos_ext - CMP_W'(1));
  assign last_idx   = IDX_W'(count_q - CNT_W'(1));
  assign rd_last    = (rd_cnt_q == last_idx);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && (s_axis_tuser == CMD_READ_ALL) && !empty) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free && rd_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d      = count_q;
    rd_cnt_d     = rd_cnt_q;
    ctrl.op      = OP_HOLD;
    ctrl.idx     = '0;
    ctrl.last    = last_idx;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_data_d   = '0;
          out_last_d   = 1'b1;
          rd_cnt_d     = '0;
          unique case (s_axis_tuser)
            CMD_INS_FRONT, CMD_INS_BACK: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else begin
                ctrl.op  = OP_INSERT;
                ctrl.idx = (s_axis_tuser == CMD_INS_FRONT) ? '0 : IDX_W'(count_q);
                count_d  = count_q + CNT_W'(1);
              end
            end
            CMD_INS_AT: begin
              if (full) begin
                out_status_d = ST_FULL;
              end else if (!ins_pos_ok) begin
                out_status_d = ST_BADPOS;
              end else begin
                ctrl.op  = OP_INSERT;
                ctrl.idx = pos_idx;
                count_d  = count_q + CNT_W'(1);
              end
            end
            CMD_DEL_BACK: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                count_d = count_q - CNT_W'(1);
              end
            end
            CMD_DEL_FRONT: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                ctrl.op  = OP_DELETE;
                ctrl.idx = '0;
                count_d  = count_q - CNT_W'(1);
              end
            end
            CMD_DEL_AT: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else if (!del_pos_ok) begin
                out_status_d = ST_BADPOS;
              end else begin
                ctrl.op  = OP_DELETE;
                ctrl.idx = pos_idx;
                count_d  = count_q - CNT_W'(1);
              end
            end
            CMD_READ_ALL: begin
              if (empty) begin
                out_status_d = ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;  // no result yet; the read state streams the entries
              end
            end
            default: out_status_d = ST_UNKNOWN;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_data_d   = head;
          out_last_d   = rd_last;
          ctrl.op      = OP_ROTATE;
          rd_cnt_d     = rd_last ? '0 : rd_cnt_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  pidl_chain u_chain (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .value_i (value),
    .head_o  (head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[rtl/core/pidl_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word and takes it from a neighbor on shifts.
// ----------------------------------------------------------------------------
module pidl_cell import pidl_pkg::*; (
  input  logic                     clk_i,
  input  logic [IDX_W-1:0]         cell_idx_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  input  logic signed [DATA_W-1:0] head_i,
  output logic signed [DATA_W-1:0] data_o
);

  logic signed [DATA_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (cell_idx_i > ctrl_i.idx) begin
          data_d = left_i;
        end else if (cell_idx_i == ctrl_i.idx) begin
          data_d = value_i;
        end
      end
      OP_DELETE: begin
        if (cell_idx_i >= ctrl_i.idx) begin
          data_d = right_i;
        end
      end
      OP_ROTATE: begin
        // read-out: head wraps around to the tail of the held entries
        if (cell_idx_i < ctrl_i.last) begin
          data_d = right_i;
        end else if (cell_idx_i == ctrl_i.last) begin
          data_d = head_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[rtl/core/pidl_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_chain
// Row of DEPTH cells wired to their neighbors; cell 0 is the list head.
// ----------------------------------------------------------------------------
module pidl_chain import pidl_pkg::*; (
  input  logic                     clk_i,
  input  cell_ctrl_t               ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic signed [DATA_W-1:0] head_o
);

  logic signed [DATA_W-1:0] cell_q [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left, right;

    if (g == 0) begin : g_first
      assign left = cell_q[g];
    end else begin : g_mid_l
      assign left = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right = cell_q[g];
    end else begin : g_mid_r
      assign right = cell_q[g+1];
    end

    pidl_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (IDX_W'(g)),
      .ctrl_i     (ctrl_i),
      .value_i    (value_i),
      .left_i     (left),
      .right_i    (right),
      .head_i     (cell_q[0]),
      .data_o     (cell_q[g])
    );
  end

  assign head_o = cell_q[0];

endmodule

[rtl/core/pidl_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidl_checker
// Port-level checks for the positional insert/delete list.
// ----------------------------------------------------------------------------
module pidl_checker import pidl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // no new request while a read stream is still open
  a_no_req_mid_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("request taken during read stream");

  // error results are single, with zero data
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error result not final or has data");

  // every request other than read all answers in the next cycle
  a_edit_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != CMD_READ_ALL)
      |=> m_axis_tvalid && m_axis_tlast)
    else $error("edit request gave no result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= ST_UNKNOWN))
    else $error("status code out of range");

endmodule

bind positional_insert_delete_list pidl_checker u_pidl_checker (.*);

[tb/positional_insert_delete_list_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_insert_delete_list_test
// Self-checking bench for the positional insert/delete list.
// ----------------------------------------------------------------------------
// A directed table walks the empty, full, bad-position and unknown-command
// cases and the value extremes. Random requests follow in three idle phases,
// with one long output hold. Each result is checked against the row's typed
// status or a queue-based list model updated as each request is accepted.
module positional_insert_delete_list_test;
  import pidl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 38;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 4;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] data;
    logic              last;
  } list_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int                reps;   // value steps by one per repeat
    bit                typed;  // expected status typed in: data zero, last set
    status_e           status;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata;   // [4:0] position, [36:5] value, [39:37] zero
  logic [2:0]        s_axis_tuser;   // [2:0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [31:0]       m_axis_tdata;   // [31:0] data
  logic [2:0]        m_axis_tuser;   // [2:0] status
  logic              m_axis_tlast;

  logic [DATA_W-1:0] list_q[$];      // model of the held entries, front first
  list_result_t      op_results_q[$];
  list_result_t      pending_q[$];   // results still owed by the block
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;
  int                error_cnt;
  int                requests_sent;
  int                results_seen;
  int                peak_len;
  int                status_hits[5];
  int                stall_cycles;

  dir_row_t dir_tbl [DIR_ROWS] = '{
    '{CMD_READ_ALL,  5'd0,  32'd0,         1,  1'b1, ST_EMPTY},
    '{CMD_DEL_BACK,  5'd0,  32'd0,         1,  1'b1, ST_EMPTY},
    '{CMD_DEL_FRONT, 5'd0,  32'd0,         1,  1'b1, ST_EMPTY},
    '{CMD_DEL_AT,    5'd31, 32'd0,         1,  1'b1, ST_EMPTY},
    '{CMD_UNKNOWN,   5'd0,  32'd0,         1,  1'b1, ST_UNKNOWN},
    '{CMD_INS_AT,    5'd0,  32'd1,         1,  1'b1, ST_BADPOS},
    '{CMD_INS_AT,    5'd2,  32'd1,         1,  1'b1, ST_BADPOS},
    '{CMD_INS_FRONT, 5'd0,  32'h7FFF_FFFF, 1,  1'b1, ST_OK},
    '{CMD_INS_BACK,  5'd0,  32'h8000_0000, 1,  1'b1, ST_OK},
    '{CMD_INS_AT,    5'd2,  32'hFFFF_FFFF, 1,  1'b1, ST_OK},
    '{CMD_INS_AT,    5'd4,  32'd0,         1,  1'b1, ST_OK},
    '{CMD_DEL_AT,    5'd0,  32'd0,         1,  1'b1, ST_BADPOS},
    '{CMD_DEL_AT,    5'd5,  32'd0,         1,  1'b1, ST_BADPOS},
    '{CMD_READ_ALL,  5'd0,  32'd0,         1,  1'b0, ST_OK},
    '{CMD_INS_AT,    5'd1,  32'h1234_5670, 12, 1'b0, ST_OK},
    '{CMD_INS_BACK,  5'd0,  32'hDEAD_BEEF, 1,  1'b1, ST_FULL},
    '{CMD_INS_FRONT, 5'd0,  32'hDEAD_BEEF, 1,  1'b1, ST_FULL},
    '{CMD_INS_AT,    5'd31, 32'hDEAD_BEEF, 1,  1'b1, ST_FULL},
    '{CMD_READ_ALL,  5'd0,  32'd0,         1,  1'b0, ST_OK},
    '{CMD_DEL_AT,    5'd16, 32'd0,         1,  1'b1, ST_OK},
    '{CMD_DEL_AT,    5'd16, 32'd0,         1,  1'b1, ST_BADPOS},
    '{CMD_DEL_FRONT, 5'd0,  32'd0,         1,  1'b1, ST_OK},
    '{CMD_DEL_BACK,  5'd0,  32'd0,         1,  1'b1, ST_OK},
    '{CMD_INS_AT,    5'd7,  32'h5555_AAAA, 1,  1'b1, ST_OK},
    '{CMD_READ_ALL,  5'd0,  32'd0,         1,  1'b0, ST_OK},
    '{CMD_UNKNOWN,   5'd31, 32'hFFFF_FFFF, 1,  1'b1, ST_UNKNOWN}
  };

  positional_insert_delete_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one request to the list model and queues the results it gives.
  function automatic void apply_list_op(input logic [CMD_W-1:0] cmd,
                                        input logic [POS_W-1:0] pos,
                                        input logic [DATA_W-1:0] val);
    int      len;
    status_e st;
    len = list_q.size();
    st  = ST_OK;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (len >= DEPTH) st = ST_FULL;
        else if (cmd == CMD_INS_FRONT) list_q.push_front(val);
        else list_q.push_back(val);
      end
      CMD_INS_AT: begin
        if (len >= DEPTH) st = ST_FULL;
        else if (pos < 1 || pos > len + 1) st = ST_BADPOS;
        else list_q.insert(pos - 1, val);
      end
      CMD_DEL_BACK: begin
        if (len == 0) st = ST_EMPTY;
        else void'(list_q.pop_back());
      end
      CMD_DEL_FRONT: begin
        if (len == 0) st = ST_EMPTY;
        else void'(list_q.pop_front());
      end
      CMD_DEL_AT: begin
        if (len == 0) st = ST_EMPTY;
        else if (pos < 1 || pos > len) st = ST_BADPOS;
        else list_q.delete(pos - 1);
      end
      CMD_READ_ALL: begin
        if (len == 0) st = ST_EMPTY;
      end
      default: st = ST_UNKNOWN;
    endcase
    status_hits[st]++;
    if (cmd == CMD_READ_ALL && len > 0) begin
      for (int i = 0; i < len; i++)
        op_results_q.push_back('{ST_OK, list_q[i], (i == len - 1)});
    end else begin
      op_results_q.push_back('{st, '0, 1'b1});
    end
    if (list_q.size() > peak_len) peak_len = list_q.size();
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val, input bit typed,
                              input status_e st);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, val, pos};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    op_results_q.delete();
    apply_list_op(cmd, pos, val);
    if (typed) pending_q.push_back('{st, '0, 1'b1});
    else foreach (op_results_q[i]) pending_q.push_back(op_results_q[i]);
    requests_sent++;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly in-range edits; ins_pct steers the list toward full or empty.
  task automatic send_random_request(input int ins_pct);
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    int                len;
    int                r;
    len = list_q.size();
    r = $urandom_range(99);
    if (r < 6) cmd = CMD_UNKNOWN;
    else if (r < 16) cmd = CMD_READ_ALL;
    else if ($urandom_range(99) < ins_pct) begin
      case ($urandom_range(2))
        0:       cmd = CMD_INS_FRONT;
        1:       cmd = CMD_INS_BACK;
        default: cmd = CMD_INS_AT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       cmd = CMD_DEL_BACK;
        1:       cmd = CMD_DEL_FRONT;
        default: cmd = CMD_DEL_AT;
      endcase
    end
    if ($urandom_range(99) < 15) pos = POS_W'($urandom_range(31));
    else if (cmd == CMD_INS_AT) pos = POS_W'($urandom_range(len + 1, 1));
    else pos = POS_W'($urandom_range((len > 0) ? len : 1, 1));
    case ($urandom_range(9))
      0:       val = 32'h7FFF_FFFF;
      1:       val = 32'h8000_0000;
      default: val = $urandom;
    endcase
    send_request(cmd, pos, val, 1'b0, ST_OK);
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    list_result_t exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        error_cnt++;
        $display("%0t: result with none expected: status %0d data %h last %b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        exp = pending_q.pop_front();
        if (m_axis_tuser !== exp.status) begin
          error_cnt++;
          $display("%0t: status expected %0d, got %0d", $time, exp.status, m_axis_tuser);
        end
        if (m_axis_tdata !== exp.data) begin
          error_cnt++;
          $display("%0t: data expected %h, got %h", $time, exp.data, m_axis_tdata);
        end
        if (m_axis_tlast !== exp.last) begin
          error_cnt++;
          $display("%0t: last expected %b, got %b", $time, exp.last, m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    hold_req      = 1'b0;
    stall_cycles  = 0;
    error_cnt     = 0;
    requests_sent = 0;
    results_seen  = 0;
    peak_len      = 0;
    send_idle_pct = 15;
    recv_idle_pct = 88;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[r]) begin
      for (int k = 0; k < dir_tbl[r].reps; k++)
        send_request(dir_tbl[r].cmd, dir_tbl[r].pos, dir_tbl[r].val + k,
                     dir_tbl[r].typed, dir_tbl[r].status);
    end

    // phase 1 leans to inserts, phase 2 to deletes, phase 3 is balanced
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request(65);
    send_idle_pct = 88;
    recv_idle_pct = 15;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request(35);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request(50);
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests and %0d results; list length peaked at %0d of %0d.",
             requests_sent, results_seen, peak_len, DEPTH);
    $display("Status counts: ok %0d, full %0d, empty %0d, bad position %0d, unknown %0d.",
             status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_EMPTY],
             status_hits[ST_BADPOS], status_hits[ST_UNKNOWN]);
    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
